@@ src/assert_macros.svh @@
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// checked only while out of reset
`define SPFQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("spfq assertion failed");
// checked at every edge, reset included
`define SPFQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("spfq assertion failed");
`else
`define SPFQ_ASSERT(lbl, clk, rst_n, prop)
`define SPFQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ src/spfq_pkg.sv @@
// types and constants of the stable priority forward queue
package spfq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int FILL_W      = 5;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 120;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic REG_BASE_ADDR = 1'b0;
  localparam logic REG_FWD_NODE  = 1'b1;

  typedef struct packed {
    logic [7:0]  prio;
    logic [31:0] uid;
    logic [7:0]  source;
    logic [7:0]  dest;
    logic [7:0]  port;
    logic [10:0] len;
    logic [7:0]  slot;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t new_ent;
  } cell_ctl_t;

endpackage

@@ src/spfq_cell.sv @@
// one slot of the sorted descriptor chain
module spfq_cell (
  input  logic               clk,
  input  spfq_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  logic               prev_displace,
  input  spfq_pkg::entry_t   prev_ent,
  input  spfq_pkg::entry_t   next_ent,
  output logic               displace,
  output spfq_pkg::entry_t   ent
);

  spfq_pkg::entry_t ent_r;
  spfq_pkg::entry_t ent_nxt;

  // strict compare keeps equal priorities in arrival order
  assign displace = !occupied || (ent_r.prio < ctl.new_ent.prio);
  assign ent      = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.pop) begin
      ent_nxt = next_ent;
    end else if (ctl.push) begin
      if (displace && !prev_displace) begin
        ent_nxt = ctl.new_ent;
      end else if (displace) begin
        ent_nxt = prev_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

@@ src/stable_priority_forward_queue.sv @@
// Stable priority queue of frame descriptors. Each request is a push (tuser 0) or a pop
// (tuser 1); one request is taken per clock and its result is held in the output register
// from the next cycle. The descriptors sit in a chain of cells kept sorted by priority, with
// equal priorities in arrival order: a push is placed by each cell comparing itself with
// the new priority in the same cycle, and a pop takes the head while the chain moves up
// by one. Input is held back only while the output register is full and not taken.
// A push on a full queue and a pop on an empty one give a status code and change nothing.
// Configuration registers may be written at any time the queue is idle; cfg_ready is
// always high.
`include "assert_macros.svh"

module stable_priority_forward_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // prio, frame_uid, source_node, dest_node, port_num, byte_len, buffer_slot, zero pad
  input  logic [spfq_pkg::IN_TDATA_W-1:0]     in_tdata,
  // cmd
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_prio, out_uid, out_source, out_dest, out_port, out_len, out_slot,
  // next_hop_address, fill_level
  output logic [spfq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // status
  output logic [1:0]                          out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [31:0]                         cfg_data
);

  localparam int DEPTH = spfq_pkg::QUEUE_DEPTH;
  localparam int CW    = spfq_pkg::CNT_W;

  logic [31:0]           base_addr_r;
  logic [7:0]            fwd_node_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic                  out_valid_r;
  logic [1:0]            status_r;
  spfq_pkg::entry_t      res_r;
  logic [31:0]           next_hop_r;
  logic [spfq_pkg::FILL_W-1:0] fill_r;

  logic                  in_acc;
  logic                  full;
  logic                  empty;
  logic                  pop_req;
  logic                  push_ok;
  logic                  pop_ok;
  spfq_pkg::entry_t      new_ent;
  spfq_pkg::cell_ctl_t   ctl;
  spfq_pkg::entry_t      ents   [DEPTH];
  logic [DEPTH-1:0]      displace;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign pop_req   = in_acc && (in_tuser == spfq_pkg::CMD_POP);
  assign push_ok   = in_acc && (in_tuser == spfq_pkg::CMD_PUSH) && !full;
  assign pop_ok    = pop_req && !empty;

  assign new_ent.prio   = in_tdata[7:0];
  assign new_ent.uid    = in_tdata[39:8];
  assign new_ent.source = in_tdata[47:40];
  assign new_ent.dest   = in_tdata[55:48];
  assign new_ent.port   = in_tdata[63:56];
  assign new_ent.len    = in_tdata[74:64];
  assign new_ent.slot   = in_tdata[82:75];

  assign ctl.push    = push_ok;
  assign ctl.pop     = pop_ok;
  assign ctl.new_ent = new_ent;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             prev_displace;
    spfq_pkg::entry_t prev_ent;
    spfq_pkg::entry_t next_ent;
    if (i == 0) begin : g_head
      assign prev_displace = 1'b0;
      assign prev_ent      = new_ent;
    end else begin : g_body
      assign prev_displace = displace[i-1];
      assign prev_ent      = ents[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_ent = ents[i];
    end else begin : g_mid
      assign next_ent = ents[i+1];
    end
    spfq_cell u_cell (
      .clk           (clk),
      .ctl           (ctl),
      .occupied      (count_r > CW'(i)),
      .prev_displace (prev_displace),
      .prev_ent      (prev_ent),
      .next_ent      (next_ent),
      .displace      (displace[i]),
      .ent           (ents[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (push_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (pop_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_addr_r <= '0;
      fwd_node_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          spfq_pkg::REG_BASE_ADDR: base_addr_r <= cfg_data;
          spfq_pkg::REG_FWD_NODE:  fwd_node_r  <= cfg_data[7:0];
          default: ;
        endcase
      end
      count_r <= count_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (in_tuser == spfq_pkg::CMD_PUSH) begin
        status_r <= full ? spfq_pkg::ST_FULL : spfq_pkg::ST_OK;
      end else begin
        status_r <= empty ? spfq_pkg::ST_EMPTY : spfq_pkg::ST_OK;
      end
      res_r      <= pop_ok ? ents[0] : '0;
      next_hop_r <= pop_ok ? (base_addr_r + {24'd0, fwd_node_r}) : 32'd0;
      fill_r     <= spfq_pkg::FILL_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {fill_r, next_hop_r, res_r.slot, res_r.len, res_r.port,
                       res_r.dest, res_r.source, res_r.uid, res_r.prio};

  `SPFQ_ASSERT(a_count_max, clk, rst_n, count_r <= CW'(DEPTH))
  `SPFQ_ASSERT(a_push_grows, clk, rst_n, push_ok |=> count_r == $past(count_r) + CW'(1))
  `SPFQ_ASSERT(a_head_sorted, clk, rst_n, (count_r >= CW'(2)) |-> ents[0].prio >= ents[1].prio)
  `SPFQ_ASSERT(a_empty_pop, clk, rst_n, (pop_req && empty) |=> out_tuser == spfq_pkg::ST_EMPTY)
  `SPFQ_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> (!out_valid_r && count_r == '0))

endmodule
